// File: rtl/fles_pkg.sv
// ----------------------------------------------------------------------------
// fles_pkg
// Shared types and constants of the flash log byte store.
// ----------------------------------------------------------------------------
package fles_pkg;

  localparam int PAGE_WORDS_DEF = 512;
  localparam int NUM_PAGES_DEF  = 4;

  localparam logic [15:0] MARK_WORD  = 16'hFEFF;
  localparam logic [15:0] BLANK_WORD = 16'hFFFF;
  localparam logic [7:0]  NO_ADDR    = 8'hFF;
  localparam logic [7:0]  NO_VALUE   = 8'hFF;
  localparam logic [7:0]  LAST_ADDR  = 8'hFE;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SEEK_GO,
    ST_SEEK,
    ST_SEEK_END,
    ST_APP_RD,
    ST_APP_WR,
    ST_CHK_RD,
    ST_CHK,
    ST_PRG_RD,
    ST_PRG_WR,
    ST_NEXT,
    ST_ERASE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic       reformatted;
    logic       compacted;
    logic       appended;
    logic [7:0] read_value;
  } res_t;

endpackage

// File: rtl/fles_mem.sv
// ----------------------------------------------------------------------------
// fles_mem
// Log word memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fles_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/fles_ctrl.sv
// ----------------------------------------------------------------------------
// fles_ctrl
// Sequencer: log search, append, compaction, page erase and store wipe.
// ----------------------------------------------------------------------------
module fles_ctrl
  import fles_pkg::*;
#(
  parameter int PAGE_WORDS = PAGE_WORDS_DEF,
  parameter int NUM_PAGES  = NUM_PAGES_DEF,
  parameter int AW         = $clog2(PAGE_WORDS * NUM_PAGES)
) (
  input  logic          clk,
  input  logic          rst_n,
  // request
  input  logic          req_valid,
  output logic          req_ready,
  input  logic          req_type,
  input  logic [7:0]    req_addr,
  input  logic [7:0]    req_value,
  // result
  output logic          res_valid,
  input  logic          res_ready,
  output res_t          res,
  // memory
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [15:0]   mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  logic [15:0]   mem_rdata
);

  localparam int TW    = PAGE_WORDS * NUM_PAGES;
  localparam int CW    = $clog2(TW + 1);
  localparam int PGW   = $clog2(NUM_PAGES);
  localparam int KW    = $clog2(PAGE_WORDS);
  localparam int LIMIT = PAGE_WORDS * (NUM_PAGES - 1) - 2;

  state_t         state_r, state_nxt;
  logic           kind_r, kind_nxt;
  logic [7:0]     addr_r, addr_nxt;
  logic [7:0]     val_r, val_nxt;
  logic [7:0]     old_r, old_nxt;
  logic [7:0]     found_r, found_nxt;
  logic [7:0]     key_r, key_nxt;
  logic [PGW-1:0] start_r, start_nxt;
  logic [AW-1:0]  sbase_r, sbase_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [CW-1:0]  pos_r, pos_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic [PGW-1:0] pg_r, pg_nxt;
  logic [KW-1:0]  wip_r, wip_nxt;
  logic [KW-1:0]  kept_r, kept_nxt;
  logic           cmp_r, cmp_nxt;
  logic           fin_r, fin_nxt;
  logic           app_r, app_nxt;
  logic           comp_r, comp_nxt;
  logic           wipe_r, wipe_nxt;

  logic [AW-1:0]  tgt_base;
  logic [PGW-1:0] tgt_page;
  logic [7:0]     skey;
  logic           hit;
  logic [CW-1:0]  count_inc;
  logic           keep_ok;
  logic [AW-1:0]  prg_addr;

  // log position to memory word, wrapping once around the store
  function automatic logic [AW-1:0] slot(input logic [CW-1:0] p, input logic [AW-1:0] sb);
    logic [CW:0] s;
    s = {1'b0, p} + (CW+1)'(sb) + (CW+1)'(1);
    if (s >= (CW+1)'(TW)) begin
      s = s - (CW+1)'(TW);
    end
    return AW'(s);
  endfunction

  // page before the start page
  assign tgt_base  = (sbase_r == '0) ? AW'(TW - PAGE_WORDS) : sbase_r - AW'(PAGE_WORDS);
  assign tgt_page  = (start_r == '0) ? PGW'(NUM_PAGES - 1) : start_r - PGW'(1);
  assign skey      = cmp_r ? key_r : addr_r;
  assign hit       = (mem_rdata[7:0] == skey);
  assign count_inc = count_r + CW'(1);
  assign keep_ok   = ((KW+1)'(kept_r) + (KW+1)'(1)) < (KW+1)'(PAGE_WORDS);
  assign prg_addr  = tgt_base + AW'(kept_r) + AW'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (idx_r == AW'(TW - 1)) state_nxt = fin_r ? ST_FINISH : ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) state_nxt = (req_addr == NO_ADDR) ? ST_FINISH : ST_SEEK_GO;
      end
      ST_SEEK_GO: state_nxt = ST_SEEK;
      ST_SEEK: begin
        if (hit || pos_r == '0) state_nxt = ST_SEEK_END;
      end
      ST_SEEK_END: begin
        if (cmp_r) begin
          state_nxt = (found_r != NO_VALUE && keep_ok) ? ST_PRG_RD : ST_NEXT;
        end else begin
          state_nxt = (kind_r == REQ_WRITE && found_r != val_r) ? ST_APP_RD : ST_FINISH;
        end
      end
      ST_APP_RD: state_nxt = ST_APP_WR;
      ST_APP_WR: state_nxt = (count_inc > CW'(LIMIT)) ? ST_CHK_RD : ST_FINISH;
      ST_CHK_RD: state_nxt = ST_CHK;
      ST_CHK:    state_nxt = (mem_rdata != BLANK_WORD) ? ST_INIT : ST_SEEK_GO;
      ST_PRG_RD: state_nxt = ST_PRG_WR;
      ST_PRG_WR: state_nxt = ST_NEXT;
      ST_NEXT:   state_nxt = (key_r == LAST_ADDR) ? ST_ERASE : ST_SEEK_GO;
      ST_ERASE: begin
        if (idx_r == AW'(TW - 1)) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (res_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  // outputs and datapath
  always_comb begin
    kind_nxt  = kind_r;
    addr_nxt  = addr_r;
    val_nxt   = val_r;
    old_nxt   = old_r;
    found_nxt = found_r;
    key_nxt   = key_r;
    start_nxt = start_r;
    sbase_nxt = sbase_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    idx_nxt   = idx_r;
    pg_nxt    = pg_r;
    wip_nxt   = wip_r;
    kept_nxt  = kept_r;
    cmp_nxt   = cmp_r;
    fin_nxt   = fin_r;
    app_nxt   = app_r;
    comp_nxt  = comp_r;
    wipe_nxt  = wipe_r;
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = BLANK_WORD;
    mem_raddr = slot(count_r, sbase_r);
    req_ready = 1'b0;
    res_valid = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = (idx_r == '0) ? MARK_WORD : BLANK_WORD;
        idx_nxt   = idx_r + AW'(1);
        if (idx_r == AW'(TW - 1)) begin
          start_nxt = '0;
          sbase_nxt = '0;
          count_nxt = '0;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          kind_nxt = req_type;
          addr_nxt = req_addr;
          val_nxt  = req_value;
          old_nxt  = NO_VALUE;
          cmp_nxt  = 1'b0;
          app_nxt  = 1'b0;
          comp_nxt = 1'b0;
          wipe_nxt = 1'b0;
        end
      end
      ST_SEEK_GO: begin
        mem_raddr = slot(count_r, sbase_r);
        pos_nxt   = count_r;
      end
      ST_SEEK: begin
        mem_raddr = slot(pos_r - CW'(1), sbase_r);
        if (hit) begin
          found_nxt = mem_rdata[15:8];
        end else if (pos_r == '0) begin
          found_nxt = NO_VALUE;
        end else begin
          pos_nxt = pos_r - CW'(1);
        end
      end
      ST_SEEK_END: begin
        if (!cmp_r) old_nxt = found_r;
      end
      ST_APP_RD: begin
        mem_raddr = slot(count_r, sbase_r);
      end
      ST_APP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = slot(count_r, sbase_r);
        mem_wdata = mem_rdata & {val_r, addr_r};
        count_nxt = count_inc;
        app_nxt   = 1'b1;
        if (count_inc > CW'(LIMIT)) comp_nxt = 1'b1;
      end
      ST_CHK_RD: begin
        mem_raddr = tgt_base;
      end
      ST_CHK: begin
        if (mem_rdata != BLANK_WORD) begin
          // target page dirty: wipe the whole store
          wipe_nxt = 1'b1;
          fin_nxt  = 1'b1;
          idx_nxt  = '0;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = tgt_base;
          mem_wdata = MARK_WORD;
          key_nxt   = '0;
          kept_nxt  = '0;
          cmp_nxt   = 1'b1;
        end
      end
      ST_PRG_RD: begin
        mem_raddr = prg_addr;
      end
      ST_PRG_WR: begin
        mem_we    = 1'b1;
        mem_waddr = prg_addr;
        mem_wdata = mem_rdata & {found_r, key_r};
        kept_nxt  = kept_r + KW'(1);
      end
      ST_NEXT: begin
        key_nxt = key_r + 8'd1;
        idx_nxt = '0;
        pg_nxt  = '0;
        wip_nxt = '0;
      end
      ST_ERASE: begin
        mem_we    = (pg_r != tgt_page);
        mem_waddr = idx_r;
        mem_wdata = BLANK_WORD;
        idx_nxt   = idx_r + AW'(1);
        if (wip_r == KW'(PAGE_WORDS - 1)) begin
          wip_nxt = '0;
          pg_nxt  = pg_r + PGW'(1);
        end else begin
          wip_nxt = wip_r + KW'(1);
        end
        if (idx_r == AW'(TW - 1)) begin
          start_nxt = tgt_page;
          sbase_nxt = tgt_base;
          count_nxt = CW'(kept_r);
        end
      end
      ST_FINISH: begin
        res_valid = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign res.read_value  = old_r;
  assign res.appended    = app_r;
  assign res.compacted   = comp_r;
  assign res.reformatted = wipe_r;

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      idx_r   <= '0;
      fin_r   <= 1'b0;
      cmp_r   <= 1'b0;
      start_r <= '0;
      sbase_r <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      fin_r   <= fin_nxt;
      cmp_r   <= cmp_nxt;
      start_r <= start_nxt;
      sbase_r <= sbase_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    addr_r  <= addr_nxt;
    val_r   <= val_nxt;
    old_r   <= old_nxt;
    found_r <= found_nxt;
    key_r   <= key_nxt;
    pos_r   <= pos_nxt;
    pg_r    <= pg_nxt;
    wip_r   <= wip_nxt;
    kept_r  <= kept_nxt;
    app_r   <= app_nxt;
    comp_r  <= comp_nxt;
    wipe_r  <= wipe_nxt;
  end

endmodule

// File: rtl/flash_log_byte_store.sv
// ----------------------------------------------------------------------------
// flash_log_byte_store
// 255-byte EEPROM emulation on a paged, append-only log of 16-bit words.
//
// channel | dir | fields
// in_     | in  | tuser: req_type; tdata: byte_address, write_value
// out_    | out | tdata: read_value, appended, compacted, reformatted
//
// One beat in, one beat out. The search of a request reads one log word
// per cycle from one memory read port. A compaction adds 255 searches
// plus one pass over all words. After reset, and after a reformat, a
// clearing pass over all PAGE_WORDS*NUM_PAGES words runs with in_tready
// low. The result register lets the next beat enter while a result waits
// on out_tready.
// ----------------------------------------------------------------------------
module flash_log_byte_store
  import fles_pkg::*;
#(
  parameter int PAGE_WORDS = PAGE_WORDS_DEF,
  parameter int NUM_PAGES  = NUM_PAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] byte_address, [15:8] write_value
  input  logic        in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [7:0] read_value, [8] appended,
                                  // [9] compacted, [10] reformatted, rest 0
);

  localparam int TW = PAGE_WORDS * NUM_PAGES;
  localparam int AW = $clog2(TW);

  logic          res_valid;
  logic          res_ready;
  res_t          res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_rdata;
  logic          out_valid_r;
  res_t          out_res_r;

  fles_ctrl #(
    .PAGE_WORDS (PAGE_WORDS),
    .NUM_PAGES  (NUM_PAGES),
    .AW         (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_type  (in_tuser),
    .req_addr  (in_tdata[7:0]),
    .req_value (in_tdata[15:8]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  fles_mem #(
    .DEPTH (TW),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result register
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_res_r};

endmodule
